FILE: rtl/core/wmmp_pkg.sv
// ----------------------------------------------------------------------------
// wmmp_pkg
// Shared widths, codes and divider handshake types for the waveform
// min/max peak extractor.
// ----------------------------------------------------------------------------
package wmmp_pkg;

  // Run limits.
  localparam int unsigned MAX_PEAKS    = 1000;
  localparam int unsigned MAX_CHANNELS = 8;

  localparam int unsigned WIN_W    = 10;  // window count and window number
  localparam int unsigned CHAN_W   = 4;   // channel_count register
  localparam int unsigned CHCNT_W  = 3;   // channel position within a frame
  localparam int unsigned FRAMES_W = 32;  // total_frames and window length
  localparam int unsigned Q_W      = 24;  // Q1.23 sample and result
  localparam int unsigned SUM_W    = 27;  // sum of up to eight Q1.23 samples
  localparam int unsigned WORD_W   = 32;  // raw sample word, config data

  localparam logic [WIN_W-1:0]  MAX_PEAKS_C    = WIN_W'(MAX_PEAKS);
  localparam logic [CHAN_W-1:0] MAX_CHANNELS_C = CHAN_W'(MAX_CHANNELS);

  // Sample format codes.
  localparam logic [1:0] FMT_PCM16 = 2'd0;
  localparam logic [1:0] FMT_PCM24 = 2'd1;
  localparam logic [1:0] FMT_F32   = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_BIG_END  = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;
  localparam logic [1:0] REG_FRAMES   = 2'd3;

  // Shared divider: 32-bit dividend by 10-bit divisor.
  localparam int unsigned DIV_N_W = 32;
  localparam int unsigned DIV_D_W = 10;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/core/waveform_min_max_peaks.sv
// ----------------------------------------------------------------------------
// waveform_min_max_peaks
// Mixes interleaved channels down to mono and reports the minimum and maximum
// frame value of each window of the clip, divided by the channel count.
//
//   channel  direction  handshake             word
//   in_      in         in_valid / in_stall   in_sample_word
//   out_     out        out_valid / out_stall peak_min, peak_max, index, last
//   cfg_     in         cfg_we                cfg_index, cfg_wdata
//
// A sample word passes through S_IDLE and S_ACC, and also S_FRAME when it
// closes a frame. A word that closes a window adds two passes of the shared
// 32-step divider. A register write restarts the run; with total_frames of
// 1000 or more it also runs the divider once, and the input stays stalled
// until it is done. Reset is synchronous. The result sits in an output
// register, so input words keep flowing while out_stall holds a result; only
// the next window result waits for it to be taken.
// ----------------------------------------------------------------------------
module waveform_min_max_peaks
  import wmmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // sample input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_W-1:0]     in_sample_word,
  // peak output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [Q_W-1:0] out_peak_min,
  output logic signed [Q_W-1:0] out_peak_max,
  output logic [WIN_W-1:0]      out_peak_index,
  output logic                  out_last_peak,
  // configuration
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [WORD_W-1:0]     cfg_wdata
);

  localparam logic [3:0] S_SETUP   = 4'd0;
  localparam logic [3:0] S_LEN     = 4'd1;
  localparam logic [3:0] S_IDLE    = 4'd2;
  localparam logic [3:0] S_ACC     = 4'd3;
  localparam logic [3:0] S_FRAME   = 4'd4;
  localparam logic [3:0] S_DIV_LO  = 4'd5;
  localparam logic [3:0] S_WAIT_LO = 4'd6;
  localparam logic [3:0] S_DIV_HI  = 4'd7;
  localparam logic [3:0] S_WAIT_HI = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0]              state_r, state_nxt;

  logic [1:0]              fmt_r, fmt_nxt;
  logic                    big_end_r, big_end_nxt;
  logic [CHAN_W-1:0]       chan_cfg_r, chan_cfg_nxt;
  logic [FRAMES_W-1:0]     frames_r, frames_nxt;

  logic [FRAMES_W-1:0]     win_len_r, win_len_nxt;
  logic [WIN_W-1:0]        win_total_r, win_total_nxt;
  logic [FRAMES_W-1:0]     frame_pos_r, frame_pos_nxt;
  logic [WIN_W-1:0]        win_cnt_r, win_cnt_nxt;
  logic [CHCNT_W-1:0]      chan_pos_r, chan_pos_nxt;
  logic                    finished_r, finished_nxt;

  logic signed [SUM_W-1:0] frame_sum_r, frame_sum_nxt;
  logic signed [SUM_W-1:0] run_min_r, run_min_nxt;
  logic signed [SUM_W-1:0] run_max_r, run_max_nxt;
  logic [WORD_W-1:0]       word_r, word_nxt;
  logic signed [Q_W-1:0]   lo_r, lo_nxt;
  logic signed [Q_W-1:0]   hi_r, hi_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [Q_W-1:0]   out_min_r, out_min_nxt;
  logic signed [Q_W-1:0]   out_max_r, out_max_nxt;
  logic [WIN_W-1:0]        out_index_r, out_index_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [CHAN_W-1:0]       chans;
  logic signed [Q_W-1:0]   sample;
  logic signed [SUM_W-1:0] sum_add;
  logic [FRAMES_W-1:0]     frame_pos_inc;
  logic [WIN_W:0]          win_cnt_inc;
  logic                    is_last;
  logic                    div_neg;
  logic signed [SUM_W-1:0] div_src;
  logic [SUM_W-1:0]        div_mag;
  logic [Q_W-1:0]          div_q;
  logic signed [Q_W-1:0]   div_signed;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  wmmp_decoder u_decoder (
    .word          (word_r),
    .sample_format (fmt_r),
    .big_endian    (big_end_r),
    .sample        (sample)
  );

  wmmp_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Channel counts above the supported maximum are clamped.
  assign chans = (chan_cfg_r > MAX_CHANNELS_C) ? MAX_CHANNELS_C : chan_cfg_r;

  assign sum_add       = frame_sum_r + SUM_W'(sample);
  assign frame_pos_inc = frame_pos_r + 1'b1;
  assign win_cnt_inc   = {1'b0, win_cnt_r} + 1'b1;
  assign is_last       = (win_cnt_inc >= {1'b0, win_total_r});

  // The extremes are divided as magnitudes so the quotient truncates toward
  // zero, then the sign goes back on.
  assign div_src    = (state_r == S_DIV_LO) ? run_min_r : run_max_r;
  assign div_mag    = div_src[SUM_W-1] ? SUM_W'(-div_src) : SUM_W'(div_src);
  assign div_neg    = run_max_r[SUM_W-1];
  assign div_q      = div_rsp.quotient[Q_W-1:0];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {{(DIV_N_W-SUM_W){1'b0}}, div_mag};
    div_req.divisor  = DIV_D_W'(chans);
    unique case (state_r)
      S_SETUP: begin
        div_req.start    = (frames_r >= FRAMES_W'(MAX_PEAKS));
        div_req.dividend = frames_r;
        div_req.divisor  = MAX_PEAKS_C;
      end
      S_DIV_LO, S_DIV_HI: div_req.start = 1'b1;
      default: div_req.start = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    fmt_nxt       = fmt_r;
    big_end_nxt   = big_end_r;
    chan_cfg_nxt  = chan_cfg_r;
    frames_nxt    = frames_r;
    win_len_nxt   = win_len_r;
    win_total_nxt = win_total_r;
    frame_pos_nxt = frame_pos_r;
    win_cnt_nxt   = win_cnt_r;
    chan_pos_nxt  = chan_pos_r;
    finished_nxt  = finished_r;
    frame_sum_nxt = frame_sum_r;
    run_min_nxt   = run_min_r;
    run_max_nxt   = run_max_r;
    word_nxt      = word_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    div_signed    = run_min_r[SUM_W-1] ? (~div_q + 1'b1) : div_q;

    unique case (state_r)
      S_SETUP: begin
        win_total_nxt = (frames_r < FRAMES_W'(MAX_PEAKS)) ? frames_r[WIN_W-1:0]
                                                          : MAX_PEAKS_C;
        frame_pos_nxt = '0;
        win_cnt_nxt   = '0;
        chan_pos_nxt  = '0;
        frame_sum_nxt = '0;
        run_min_nxt   = '0;
        run_max_nxt   = '0;
        finished_nxt  = 1'b0;
        if (frames_r >= FRAMES_W'(MAX_PEAKS)) begin
          state_nxt = S_LEN;
        end else begin
          // Fewer frames than peaks: one frame a window, or none at all.
          win_len_nxt = (frames_r != '0) ? FRAMES_W'(1) : '0;
          state_nxt   = S_IDLE;
        end
      end
      S_LEN: begin
        if (div_rsp.done) begin
          win_len_nxt = div_rsp.quotient;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          word_nxt  = in_sample_word;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (finished_r || win_total_r == '0 || chans == '0) begin
          state_nxt = S_IDLE;
        end else begin
          frame_sum_nxt = sum_add;
          if ({1'b0, chan_pos_r} + 1'b1 < chans) begin
            chan_pos_nxt = chan_pos_r + 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            chan_pos_nxt = '0;
            state_nxt    = S_FRAME;
          end
        end
      end
      S_FRAME: begin
        if (frame_pos_r == '0) begin
          run_min_nxt = frame_sum_r;
          run_max_nxt = frame_sum_r;
        end else begin
          if (frame_sum_r < run_min_r) run_min_nxt = frame_sum_r;
          if (frame_sum_r > run_max_r) run_max_nxt = frame_sum_r;
        end
        frame_sum_nxt = '0;
        if (frame_pos_inc < win_len_r) begin
          frame_pos_nxt = frame_pos_inc;
          state_nxt     = S_IDLE;
        end else begin
          frame_pos_nxt = '0;
          state_nxt     = S_DIV_LO;
        end
      end
      S_DIV_LO: state_nxt = S_WAIT_LO;
      S_WAIT_LO: begin
        if (div_rsp.done) begin
          lo_nxt    = div_signed;
          state_nxt = S_DIV_HI;
        end
      end
      S_DIV_HI: state_nxt = S_WAIT_HI;
      S_WAIT_HI: begin
        if (div_rsp.done) begin
          hi_nxt    = div_neg ? (~div_q + 1'b1) : div_q;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Wait until the previous word has left the output register.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = lo_r;
          out_max_nxt   = hi_r;
          out_index_nxt = win_cnt_r;
          out_last_nxt  = is_last;
          win_cnt_nxt   = win_cnt_inc[WIN_W-1:0];
          if (is_last) finished_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A register write restarts the run.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT:   fmt_nxt      = cfg_wdata[1:0];
        REG_BIG_END:  big_end_nxt  = cfg_wdata[0];
        REG_CHANNELS: chan_cfg_nxt = cfg_wdata[CHAN_W-1:0];
        REG_FRAMES:   frames_nxt   = cfg_wdata;
        default:      fmt_nxt      = fmt_r;
      endcase
      state_nxt = S_SETUP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SETUP;
      fmt_r       <= FMT_PCM16;
      big_end_r   <= 1'b0;
      chan_cfg_r  <= CHAN_W'(1);
      frames_r    <= '0;
      win_len_r   <= '0;
      win_total_r <= '0;
      frame_pos_r <= '0;
      win_cnt_r   <= '0;
      chan_pos_r  <= '0;
      finished_r  <= 1'b0;
      frame_sum_r <= '0;
      run_min_r   <= '0;
      run_max_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fmt_r       <= fmt_nxt;
      big_end_r   <= big_end_nxt;
      chan_cfg_r  <= chan_cfg_nxt;
      frames_r    <= frames_nxt;
      win_len_r   <= win_len_nxt;
      win_total_r <= win_total_nxt;
      frame_pos_r <= frame_pos_nxt;
      win_cnt_r   <= win_cnt_nxt;
      chan_pos_r  <= chan_pos_nxt;
      finished_r  <= finished_nxt;
      frame_sum_r <= frame_sum_nxt;
      run_min_r   <= run_min_nxt;
      run_max_r   <= run_max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_peak_min   = out_min_r;
  assign out_peak_max   = out_max_r;
  assign out_peak_index = out_index_r;
  assign out_last_peak  = out_last_r;

endmodule

FILE: rtl/core/wmmp_divider.sv
// ----------------------------------------------------------------------------
// wmmp_divider
// Restoring unsigned divider, one quotient bit per cycle. Shared between the
// window length setup and the per-window division by the channel count.
// ----------------------------------------------------------------------------
module wmmp_divider
  import wmmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0]   dq_r, dq_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   divisor_r, divisor_nxt;

  logic [DIV_D_W:0]     rem_shift;
  logic [DIV_D_W:0]     rem_diff;
  logic                 fits;

  // The dividend shifts out of the top of dq_r while quotient bits enter at
  // the bottom, so dq_r holds the quotient once every bit has gone through.
  assign rem_shift = {rem_r, dq_r[DIV_N_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor_r};
  assign fits      = (rem_shift >= {1'b0, divisor_r});

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    dq_nxt      = dq_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      dq_nxt      = req.dividend;
      rem_nxt     = '0;
      divisor_nxt = req.divisor;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DIV_N_W-2:0], fits};
      rem_nxt = fits ? rem_diff[DIV_D_W-1:0] : rem_shift[DIV_D_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

FILE: rtl/core/wmmp_decoder.sv
// ----------------------------------------------------------------------------
// wmmp_decoder
// Turns one raw sample word into a signed Q1.23 value: 16-bit or 24-bit PCM
// or 32-bit float, little or big endian. Floats saturate, NaN gives zero.
// ----------------------------------------------------------------------------
module wmmp_decoder
  import wmmp_pkg::*;
(
  input  logic [WORD_W-1:0]     word,
  input  logic [1:0]            sample_format,
  input  logic                  big_endian,
  output logic signed [Q_W-1:0] sample
);

  logic [7:0]        b0, b1, b2, b3;
  logic [15:0]       v16;
  logic [23:0]       v24;
  logic [31:0]       v32;
  logic              f_sign;
  logic [7:0]        f_exp;
  logic [22:0]       f_man;
  logic [7:0]        f_shift;
  logic [Q_W-1:0]    f_mag;
  logic [Q_W-1:0]    f_q;

  assign b0 = word[7:0];
  assign b1 = word[15:8];
  assign b2 = word[23:16];
  assign b3 = word[31:24];

  assign v16 = big_endian ? {b0, b1} : {b1, b0};
  assign v24 = big_endian ? {b0, b1, b2} : {b2, b1, b0};
  assign v32 = big_endian ? {b0, b1, b2, b3} : {b3, b2, b1, b0};

  assign f_sign  = v32[31];
  assign f_exp   = v32[30:23];
  assign f_man   = v32[22:0];
  assign f_shift = 8'd127 - f_exp;
  assign f_mag   = {1'b1, f_man} >> f_shift[4:0];

  always_comb begin
    priority if (f_exp == 8'hFF && f_man != '0) begin
      f_q = '0;
    end else if (f_exp >= 8'd127) begin
      f_q = f_sign ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else if (f_shift >= 8'd24) begin
      f_q = '0;
    end else begin
      f_q = f_sign ? (~f_mag + 1'b1) : f_mag;
    end
  end

  always_comb begin
    unique case (sample_format)
      FMT_PCM16: sample = {v16, 8'h00};
      FMT_PCM24: sample = v24;
      FMT_F32:   sample = f_q;
      FMT_NONE:  sample = '0;
      default:   sample = '0;
    endcase
  end

endmodule
